// File: rtl/lfs_pkg.sv
// ----------------------------------------------------------------------------
// lfs_pkg
// Shared types and constants for the LED fade on/off sequencer.
// ----------------------------------------------------------------------------
package lfs_pkg;

   localparam int FRACTION_BITS = 14;
   localparam int TIME_BITS     = 32;
   localparam int COLOR_BITS    = 8;
   localparam int NUM_LANES     = 3;
   localparam int CNT_BITS      = $clog2(FRACTION_BITS + 1);
   localparam int PROD_BITS     = FRACTION_BITS + COLOR_BITS;

   // item kinds carried in req_tuser
   typedef enum logic [1:0] {
      FUNC_TICK    = 2'd0,
      FUNC_IGNITE  = 2'd1,
      FUNC_RETRACT = 2'd2
   } func_type;

   // blade phase, reported on the result channel
   typedef enum logic [1:0] {
      PH_OFF     = 2'd0,
      PH_IGNITE  = 2'd1,
      PH_ON      = 2'd2,
      PH_RETRACT = 2'd3
   } phase_type;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_DIV  = 3'b010,
      ST_OUT  = 3'b100
   } state_type;

   // lane control: one product per fade tick
   typedef struct packed {
      logic                     load;
      logic                     retract;
      logic [FRACTION_BITS-1:0] fraction;
   } lane_ctl_type;

endpackage

// File: rtl/lfs_divider.sv
// ----------------------------------------------------------------------------
// lfs_divider
// Restoring divider: fraction = (elapsed << FRACTION_BITS) / length,
// one quotient bit per cycle. Requires elapsed < length.
// ----------------------------------------------------------------------------
module lfs_divider (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [lfs_pkg::TIME_BITS-1:0]     dividend,
   input  logic [lfs_pkg::TIME_BITS-1:0]     divisor,
   output logic                              done,
   output logic [lfs_pkg::FRACTION_BITS-1:0] quotient
);

   logic [lfs_pkg::TIME_BITS-1:0]     rem_ff, rem_in;
   logic [lfs_pkg::TIME_BITS-1:0]     div_ff, div_in;
   logic [lfs_pkg::FRACTION_BITS-1:0] quo_ff, quo_in;
   logic [lfs_pkg::CNT_BITS-1:0]      cnt_ff, cnt_in;
   logic                              busy_ff, busy_in;
   logic                              done_ff, done_in;
   logic [lfs_pkg::TIME_BITS:0]       shifted;
   logic [lfs_pkg::TIME_BITS:0]       diff;
   logic                              fits;

   assign shifted = {rem_ff, 1'b0};
   assign diff    = shifted - {1'b0, div_ff};
   assign fits    = (shifted >= {1'b0, div_ff});

   always_comb begin
      rem_in  = rem_ff;
      div_in  = div_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = dividend;
         div_in  = divisor;
         cnt_in  = lfs_pkg::CNT_BITS'(lfs_pkg::FRACTION_BITS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? diff[lfs_pkg::TIME_BITS-1:0] : shifted[lfs_pkg::TIME_BITS-1:0];
         quo_in = {quo_ff[lfs_pkg::FRACTION_BITS-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == lfs_pkg::CNT_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      div_ff <= div_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// File: rtl/lfs_lane.sv
// ----------------------------------------------------------------------------
// lfs_lane
// One color channel of the fade: registered fraction*color product, then
// floor scaling for ignite or ceiling-subtract for retract.
// ----------------------------------------------------------------------------
module lfs_lane (
   input  logic                           clock,
   input  lfs_pkg::lane_ctl_type          ctl,
   input  logic [lfs_pkg::COLOR_BITS-1:0] color,
   output logic [lfs_pkg::COLOR_BITS-1:0] level
);

   logic [lfs_pkg::PROD_BITS-1:0] prod_ff;
   logic [lfs_pkg::PROD_BITS-1:0] prod_in;
   logic [lfs_pkg::PROD_BITS:0]   rounded;
   logic [lfs_pkg::COLOR_BITS-1:0] down;

   assign prod_in = lfs_pkg::PROD_BITS'(ctl.fraction) * lfs_pkg::PROD_BITS'(color);

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         prod_ff <= prod_in;
      end
   end

   // ceiling of product / 2^FRACTION_BITS, never above color
   assign rounded = {1'b0, prod_ff}
                  + (lfs_pkg::PROD_BITS+1)'((1 << lfs_pkg::FRACTION_BITS) - 1);
   assign down    = rounded[lfs_pkg::PROD_BITS-1:lfs_pkg::FRACTION_BITS];

   assign level = ctl.retract ? (color - down)
                              : prod_ff[lfs_pkg::PROD_BITS-1:lfs_pkg::FRACTION_BITS];

endmodule

// File: rtl/led_fade_on_off_sequencer_unit.sv
// ----------------------------------------------------------------------------
// led_fade_on_off_sequencer_unit
// Four-phase LED driver (off, igniting, on, retracting) with linear fades.
// ----------------------------------------------------------------------------
// channel | dir | tdata (low bit up)                          | tuser
// req     | in  | duration 32, now_time 32, red, green, blue  | func 2
// rsp     | out | out_red, out_green, out_blue, phase 2, pad  | -
//
// Ignite, retract and unused items: taken without leaving idle, no result.
// Tick outside a fade: ST_OUT, then the output register once it is free, then idle.
// Tick in a fade: ST_DIV while the bit-serial divider runs, the lanes register
// the product, then ST_OUT and the output register, then idle for the next item.
// One item at a time; a finished result waits in the output register while
// the next item is taken. Reset is synchronous and clears phase and times.
// ----------------------------------------------------------------------------
module led_fade_on_off_sequencer_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [87:0] req_tdata,   // duration, now_time, full_red, full_green, full_blue
   input  logic [1:0]  req_tuser,   // func
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata    // out_red, out_green, out_blue, phase, zero pad
);

   localparam int TB = lfs_pkg::TIME_BITS;
   localparam int CB = lfs_pkg::COLOR_BITS;

   // input fields
   logic [TB-1:0] in_duration;
   logic [TB-1:0] in_now;
   logic [CB-1:0] in_color [lfs_pkg::NUM_LANES];

   assign in_duration = req_tdata[TB-1:0];
   assign in_now      = req_tdata[32 +: TB];
   assign in_color[0] = req_tdata[71:64];
   assign in_color[1] = req_tdata[79:72];
   assign in_color[2] = req_tdata[87:80];

   // sequencer state
   lfs_pkg::state_type state_ff, state_in;
   lfs_pkg::phase_type phase_ff, phase_in;
   logic [TB-1:0]      fade_len_ff, fade_len_in;
   logic [TB-1:0]      fade_start_ff, fade_start_in;
   logic [TB-1:0]      last_tick_ff, last_tick_in;
   logic [CB-1:0]      color_ff [lfs_pkg::NUM_LANES];

   // output register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [31:0]        rsp_data_ff, rsp_data_in;

   logic               accept;
   logic               is_tick;
   logic [TB-1:0]      elapsed;
   logic               fade_done;
   logic               fading;
   logic               div_start;
   logic               div_done;
   logic [lfs_pkg::FRACTION_BITS-1:0] div_quo;
   lfs_pkg::lane_ctl_type lane_ctl;
   logic [CB-1:0]      lane_level [lfs_pkg::NUM_LANES];
   logic [CB-1:0]      merged [lfs_pkg::NUM_LANES];
   logic               out_free;

   assign req_tready = (state_ff == lfs_pkg::ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign is_tick    = (req_tuser == lfs_pkg::FUNC_TICK);
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // elapsed time is zero while no fade runs; wraps modulo 2^TIME_BITS
   assign elapsed   = (fade_len_ff != '0) ? (in_now - fade_start_ff) : '0;
   assign fade_done = ((phase_ff == lfs_pkg::PH_IGNITE) || (phase_ff == lfs_pkg::PH_RETRACT))
                    && (elapsed >= fade_len_ff);
   assign fading    = ((phase_ff == lfs_pkg::PH_IGNITE) || (phase_ff == lfs_pkg::PH_RETRACT))
                    && !fade_done;
   assign div_start = accept && is_tick && fading;

   always_comb begin
      state_in      = state_ff;
      phase_in      = phase_ff;
      fade_len_in   = fade_len_ff;
      fade_start_in = fade_start_ff;
      last_tick_in  = last_tick_ff;
      unique case (state_ff)
         lfs_pkg::ST_IDLE: begin
            if (accept) begin
               case (req_tuser)
                  lfs_pkg::FUNC_TICK: begin
                     last_tick_in = in_now;
                     if (fade_done) begin
                        phase_in      = (phase_ff == lfs_pkg::PH_IGNITE) ? lfs_pkg::PH_ON
                                                                         : lfs_pkg::PH_OFF;
                        fade_len_in   = '0;
                        fade_start_in = '0;
                     end
                     state_in = fading ? lfs_pkg::ST_DIV : lfs_pkg::ST_OUT;
                  end
                  lfs_pkg::FUNC_IGNITE: begin
                     if (phase_ff == lfs_pkg::PH_OFF) begin
                        phase_in      = lfs_pkg::PH_IGNITE;
                        fade_len_in   = in_duration;
                        fade_start_in = last_tick_ff;
                     end
                  end
                  lfs_pkg::FUNC_RETRACT: begin
                     if (phase_ff == lfs_pkg::PH_ON) begin
                        phase_in      = lfs_pkg::PH_RETRACT;
                        fade_len_in   = in_duration;
                        fade_start_in = last_tick_ff;
                     end
                  end
                  default: ; // unused code: dropped
               endcase
            end
         end
         lfs_pkg::ST_DIV: begin
            // lanes capture fraction*color in the cycle the divider finishes
            if (div_done) begin
               state_in = lfs_pkg::ST_OUT;
            end
         end
         lfs_pkg::ST_OUT: begin
            if (out_free) begin
               state_in = lfs_pkg::ST_IDLE;
            end
         end
         default: state_in = lfs_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= lfs_pkg::ST_IDLE;
         phase_ff      <= lfs_pkg::PH_OFF;
         fade_len_ff   <= '0;
         fade_start_ff <= '0;
         last_tick_ff  <= '0;
      end else begin
         state_ff      <= state_in;
         phase_ff      <= phase_in;
         fade_len_ff   <= fade_len_in;
         fade_start_ff <= fade_start_in;
         last_tick_ff  <= last_tick_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && is_tick) begin
         color_ff <= in_color;
      end
   end

   lfs_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (elapsed),
      .divisor  (fade_len_ff),
      .done     (div_done),
      .quotient (div_quo)
   );

   // one lane per color channel
   assign lane_ctl.load     = (state_ff == lfs_pkg::ST_DIV) && div_done;
   assign lane_ctl.retract  = (phase_ff == lfs_pkg::PH_RETRACT);
   assign lane_ctl.fraction = div_quo;

   for (genvar g = 0; g < lfs_pkg::NUM_LANES; g++) begin : g_lane
      lfs_lane u_lane (
         .clock (clock),
         .ctl   (lane_ctl),
         .color (color_ff[g]),
         .level (lane_level[g])
      );
   end

   // merge: black when off, full color when on, lane results in a fade
   always_comb begin
      for (int i = 0; i < lfs_pkg::NUM_LANES; i++) begin
         case (phase_ff)
            lfs_pkg::PH_OFF: merged[i] = '0;
            lfs_pkg::PH_ON:  merged[i] = color_ff[i];
            default:         merged[i] = lane_level[i];
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      if ((state_ff == lfs_pkg::ST_OUT) && out_free) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {6'd0, phase_ff, merged[2], merged[1], merged[0]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// File: rtl/lfs_checker.sv
// ----------------------------------------------------------------------------
// lfs_checker
// Port-level checks for the LED fade sequencer, bound to the top level.
// ----------------------------------------------------------------------------
module lfs_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [1:0]  req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata
);

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // a tick is worked on alone
   a_tick_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser == lfs_pkg::FUNC_TICK) |=> !req_tready)
      else $error("input taken right after a tick");

   // items other than ticks make no result
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser != lfs_pkg::FUNC_TICK) && !rsp_tvalid
      |=> !rsp_tvalid)
      else $error("result without a tick");

   // off means black
   a_off_black: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[25:24] == lfs_pkg::PH_OFF) |-> (rsp_tdata[23:0] == 24'd0))
      else $error("color driven while off");

   // reset leaves the block idle and empty
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("not idle after reset");

endmodule

bind led_fade_on_off_sequencer_unit lfs_checker u_lfs_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// File: tb/sv/tb_led_fade_on_off_sequencer_unit.sv
// ----------------------------------------------------------------------------
// tb_led_fade_on_off_sequencer_unit
// Drives ignite, retract, tick and spare items into the LED fade sequencer
// and checks every color/phase result against a cycle-free predictor.
// A short directed run covers zero and full-length fades, ignored commands,
// the spare code and time wrap; random fade cycles with noise follow, under
// several sender/receiver idle mixes and one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_led_fade_on_off_sequencer_unit;

   localparam logic [1:0]  FUNC_SPARE  = 2'd3;     // unused code, dropped by the block
   localparam int          HOLD_CYCLES = 300;      // long receiver hold-off
   localparam int          CYCLE_LIMIT = 400000;
   localparam int          DRAIN_WAIT  = 40;       // beyond the longest tick latency
   localparam logic [63:0] FULL_SCALE  = 64'd1 << lfs_pkg::FRACTION_BITS;

   typedef struct {
      logic [1:0]  func;
      logic [87:0] data;   // duration, now_time, red, green, blue (low bits up)
   } led_item_type;

   typedef struct packed {
      logic [7:0]         blue;
      logic [7:0]         green;
      logic [7:0]         red;
      lfs_pkg::phase_type phase;
   } led_out_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [87:0] req_tdata  = '0;
   logic [1:0]  req_tuser  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;

   led_item_type pending_items[$];
   led_out_type  expected_leds[$];
   led_item_type next_item;
   bit          req_taken = 1'b0;
   int unsigned send_idle_pct = 0;
   int unsigned recv_stall_pct = 0;
   bit          hold_req = 1'b0;
   int unsigned hold_left = 0;
   int unsigned cycle_count = 0;
   int unsigned error_count = 0;
   int unsigned items_queued = 0;
   logic [31:0] stim_now = '0;

   // predictor state
   lfs_pkg::phase_type fade_phase = lfs_pkg::PH_OFF;
   logic [31:0] fade_len   = '0;
   logic [31:0] fade_t0    = '0;
   logic [31:0] tick_last  = '0;

   led_fade_on_off_sequencer_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #6 clock = ~clock;

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      error_count++;
      if (error_count <= 100)
         $display("mismatch %s: got %0h want %0h (cycle %0d)", what, got, want, cycle_count);
   endtask

   // Applies one accepted item to the sequencer state; ticks yield a color.
   task automatic advance_fader(input logic [1:0] func, input logic [87:0] data);
      logic [31:0] dur;
      logic [31:0] now;
      logic [31:0] elapsed;
      logic [7:0]  full [3];
      logic [7:0]  level [3];
      logic [63:0] frac;
      logic [63:0] prod;
      led_out_type res;
      int          i;
      dur     = data[31:0];
      now     = data[63:32];
      full[0] = data[71:64];
      full[1] = data[79:72];
      full[2] = data[87:80];
      elapsed = '0;
      case (func)
         lfs_pkg::FUNC_IGNITE: begin
            if (fade_phase == lfs_pkg::PH_OFF) begin
               fade_phase = lfs_pkg::PH_IGNITE;
               fade_len   = dur;
               fade_t0    = tick_last;
            end
         end
         lfs_pkg::FUNC_RETRACT: begin
            if (fade_phase == lfs_pkg::PH_ON) begin
               fade_phase = lfs_pkg::PH_RETRACT;
               fade_len   = dur;
               fade_t0    = tick_last;
            end
         end
         lfs_pkg::FUNC_TICK: begin
            tick_last = now;
            if (fade_len != 0) elapsed = now - fade_t0;   // modulo 2^32
            if (fade_phase == lfs_pkg::PH_IGNITE && elapsed >= fade_len) begin
               fade_phase = lfs_pkg::PH_ON;
               fade_t0    = '0;
               fade_len   = '0;
            end else if (fade_phase == lfs_pkg::PH_RETRACT && elapsed >= fade_len) begin
               fade_phase = lfs_pkg::PH_OFF;
               fade_t0    = '0;
               fade_len   = '0;
            end
            frac = '0;
            if (fade_len != 0)
               frac = ({32'd0, elapsed} << lfs_pkg::FRACTION_BITS) / {32'd0, fade_len};
            if (frac > FULL_SCALE) frac = FULL_SCALE;
            for (i = 0; i < 3; i++) begin
               prod = frac * full[i];
               case (fade_phase)
                  lfs_pkg::PH_ON:      level[i] = full[i];
                  lfs_pkg::PH_IGNITE:  level[i] = 8'(prod >> lfs_pkg::FRACTION_BITS);
                  // fading down rounds the drop up, so the level floors
                  lfs_pkg::PH_RETRACT:
                     level[i] = full[i]
                              - 8'((prod + FULL_SCALE - 1) >> lfs_pkg::FRACTION_BITS);
                  default:             level[i] = '0;
               endcase
            end
            res.red   = level[0];
            res.green = level[1];
            res.blue  = level[2];
            res.phase = fade_phase;
            expected_leds.push_back(res);
         end
         default: ;   // spare code: no state change, no result
      endcase
   endtask

   // Monitor: result check, then input capture for the predictor.
   always @(posedge clock) begin
      led_out_type want;
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("FAIL");
         $finish;
      end
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_leds.size() == 0) begin
               report_mismatch("unexpected result", rsp_tdata, '0);
            end else begin
               want = expected_leds.pop_front();
               if (rsp_tdata[7:0] !== want.red) report_mismatch("red", rsp_tdata[7:0], want.red);
               if (rsp_tdata[15:8] !== want.green)
                  report_mismatch("green", rsp_tdata[15:8], want.green);
               if (rsp_tdata[23:16] !== want.blue)
                  report_mismatch("blue", rsp_tdata[23:16], want.blue);
               if (rsp_tdata[25:24] !== want.phase)
                  report_mismatch("phase", rsp_tdata[25:24], want.phase);
            end
         end
         if (req_tvalid && req_tready) begin
            advance_fader(req_tuser, req_tdata);
            req_taken = 1'b1;
         end
      end
   end

   // Driver: holds an item until taken, idles at random between items.
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (req_tvalid && !req_taken) begin
         // still waiting for the handshake
      end else begin
         req_taken = 1'b0;
         if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            next_item = pending_items.pop_front();
            req_tuser  <= next_item.func;
            req_tdata  <= next_item.data;
            req_tvalid <= 1'b1;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Receiver: random stalls, plus a long hold-off counted here.
   always @(negedge clock) begin
      if (hold_req) begin
         hold_left = HOLD_CYCLES;
         hold_req  = 1'b0;
      end
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   task automatic queue_item(input logic [1:0] func, input logic [31:0] dur,
                             input logic [31:0] now, input logic [7:0] r,
                             input logic [7:0] g, input logic [7:0] b);
      led_item_type it;
      it.func = func;
      it.data = {b, g, r, now, dur};
      pending_items.push_back(it);
      items_queued++;
   endtask

   function automatic logic [7:0] random_level();
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 10) return 8'd0;
      if (pick < 20) return 8'd255;
      return 8'($urandom_range(255));
   endfunction

   // duration field is ignored on ticks, so it carries random bits
   task automatic queue_tick(input logic [31:0] now);
      queue_item(lfs_pkg::FUNC_TICK, $urandom, now, random_level(), random_level(),
                 random_level());
   endtask

   function automatic logic [31:0] pick_duration();
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 8) return '0;
      if (pick < 14) return $urandom;
      if (pick < 18) return '1;
      return $urandom_range(1, 4000);
   endfunction

   // One full fade up and fade down, starting from off.
   task automatic queue_fade_cycle();
      logic [31:0] dur;
      logic [31:0] t0;
      logic [31:0] last_off;
      int unsigned n;
      int unsigned j;
      int unsigned k;
      for (k = 0; k < 2; k++) begin
         dur = pick_duration();
         stim_now += $urandom_range(1, 50);
         queue_tick(stim_now);   // this tick becomes the fade start
         queue_item((k == 0) ? lfs_pkg::FUNC_IGNITE : lfs_pkg::FUNC_RETRACT, dur, $urandom,
                    8'($urandom), 8'($urandom), 8'($urandom));
         t0 = stim_now;
         n  = $urandom_range(1, 6);
         for (j = 1; j < n; j++)
            queue_tick(t0 + (dur / n) * j + $urandom_range(0, 2));
         if (dur != 0 && $urandom_range(3) == 0) queue_tick(t0 + dur - 1);   // one short
         last_off = (dur == '1) ? dur : dur + $urandom_range(0, 1);
         stim_now = t0 + last_off;
         queue_tick(stim_now);
         repeat ($urandom_range(0, 3)) begin   // steady on or off
            stim_now += $urandom_range(1, 100);
            queue_tick(stim_now);
         end
      end
   endtask

   task automatic queue_noise();
      logic [31:0] now;
      now = ($urandom_range(3) == 0) ? $urandom : stim_now + $urandom_range(0, 500);
      queue_item(2'($urandom_range(0, 3)), $urandom, now,
                 8'($urandom), 8'($urandom), 8'($urandom));
   endtask

   task automatic queue_random(input int unsigned count);
      int unsigned target;
      target = items_queued + count;
      while (items_queued < target) begin
         if ($urandom_range(99) < 20) queue_noise();
         else queue_fade_cycle();
      end
   endtask

   task automatic wait_accepted();
      while (pending_items.size() != 0 || req_tvalid) @(posedge clock);
   endtask

   task automatic run_phase(input int unsigned send_pct, input int unsigned recv_pct,
                            input int unsigned count);
      send_idle_pct  = send_pct;
      recv_stall_pct = recv_pct;
      queue_random(count);
      wait_accepted();
   endtask

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: idle state, ignored commands, spare code, zero-length and
      // full-length fades, boundaries and a fade across time wrap
      queue_item(lfs_pkg::FUNC_TICK,    '1, 32'd0, 8'hFF, 8'hFF, 8'hFF);
      queue_item(lfs_pkg::FUNC_RETRACT, 32'd5, '0, 8'h00, 8'h00, 8'h00);
      queue_item(FUNC_SPARE,            '1, '1, 8'hFF, 8'hFF, 8'hFF);
      queue_item(lfs_pkg::FUNC_IGNITE,  32'd0, '1, 8'hFF, 8'hFF, 8'hFF);
      queue_item(lfs_pkg::FUNC_TICK,    32'd0, 32'd10, 8'hFF, 8'hFF, 8'hFF);
      queue_item(lfs_pkg::FUNC_IGNITE,  32'd100, 32'd0, 8'h00, 8'h00, 8'h00);
      queue_item(lfs_pkg::FUNC_TICK,    32'd0, 32'd20, 8'h00, 8'h00, 8'h00);
      queue_item(lfs_pkg::FUNC_RETRACT, '1, 32'd0, 8'h00, 8'h00, 8'h00);
      queue_item(lfs_pkg::FUNC_TICK,    32'd0, 32'h8000_0014, 8'hFF, 8'h80, 8'h01);
      queue_item(lfs_pkg::FUNC_TICK,    32'd0, 32'd19, 8'hFF, 8'hFF, 8'hFF);
      queue_item(lfs_pkg::FUNC_TICK,    32'd0, 32'hFFFF_FFF0, 8'hFF, 8'hFF, 8'hFF);
      queue_item(lfs_pkg::FUNC_IGNITE,  32'd64, 32'd0, 8'h00, 8'h00, 8'h00);
      queue_item(lfs_pkg::FUNC_TICK,    32'd0, 32'h0000_0010, 8'd200, 8'd100, 8'd50);
      queue_item(lfs_pkg::FUNC_TICK,    32'd0, 32'h0000_002F, 8'hFF, 8'hFF, 8'hFF);
      queue_item(lfs_pkg::FUNC_TICK,    32'd0, 32'h0000_0030, 8'hFF, 8'h7F, 8'h01);
      queue_item(lfs_pkg::FUNC_RETRACT, 32'd3, 32'd0, 8'h00, 8'h00, 8'h00);
      queue_item(lfs_pkg::FUNC_TICK,    32'd0, 32'h0000_0031, 8'hFF, 8'hFF, 8'hFF);
      queue_item(lfs_pkg::FUNC_TICK,    32'd0, 32'h0000_0033, 8'hFF, 8'hFF, 8'hFF);
      queue_item(FUNC_SPARE,            '0, '0, 8'h00, 8'h00, 8'h00);
      queue_item(lfs_pkg::FUNC_TICK,    '0, 32'd0, 8'h00, 8'h00, 8'h00);
      wait_accepted();
      stim_now = '0;

      run_phase(0, 0, 250);
      run_phase(51, 0, 250);
      run_phase(0, 51, 250);
      run_phase(7, 7, 200);

      // receiver holds off while the sender keeps offering
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      queue_random(150);
      @(posedge clock);
      hold_req = 1'b1;
      wait_accepted();

      while (expected_leds.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (error_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

// File: sim.f
rtl/lfs_pkg.sv
rtl/lfs_divider.sv
rtl/lfs_lane.sv
rtl/led_fade_on_off_sequencer_unit.sv
rtl/lfs_checker.sv
tb/sv/tb_led_fade_on_off_sequencer_unit.sv
